[src/pid_yaw_controller_deadband_core_assert.svh]
// assertion macros for the yaw-rate controller blocks
// expects clk and rst in the including module's scope
`ifndef PID_YAW_CONTROLLER_DEADBAND_CORE_ASSERT_SVH
`define PID_YAW_CONTROLLER_DEADBAND_CORE_ASSERT_SVH

// same-cycle implication
`define PYC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pyc: assertion failed");

// next-cycle implication
`define PYC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pyc: assertion failed");

`endif

[src/pyc_pkg.sv]
// shared types, constants and the microcode rom of the yaw-rate controller
// no dependencies
`default_nettype none

package pyc_pkg;

  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned ANGLE_W    = 15;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned PC_W       = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 16;
  localparam int unsigned M_TUSER_W  = 1;

  localparam int unsigned MUL_A_W    = 32;
  localparam int unsigned MUL_B_W    = 25;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned WIDE_W     = 80;
  localparam int unsigned DIVIDEND_W = 56;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W / 2;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned TERM_W     = 50;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;

  localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd5;

  localparam logic signed [GAIN_W-1:0] KP_RESET = 32'sd262144;
  localparam logic signed [GAIN_W-1:0] KI_RESET = 32'sd0;
  localparam logic signed [GAIN_W-1:0] KD_RESET = 32'sd6554;
  localparam logic [LIMIT_W-1:0] RATE_LIMIT_RESET = 15'd4096;
  localparam logic [LIMIT_W-1:0] DEAD_BAND_RESET  = 15'd4;
  localparam logic [MS_W-1:0]    PERIOD_RESET     = 16'd100;

  localparam logic [DIVISOR_W-1:0] MS_PER_S = 16'd1000;

  // integral saturates at +/-(2^47 - 1)
  localparam logic signed [ACC_W:0] ACC_HI = $signed({2'b00, {47{1'b1}}});
  localparam logic signed [ACC_W:0] ACC_LO = $signed({2'b11, {46{1'b0}}, 1'b1});
  // 1000 * 2^62: integral term reaches 2^46 at or above this product
  localparam logic [WIDE_W-1:0] I_SAT_LIM = {8'b0, 10'd1000, 62'b0};
  localparam logic [TERM_W-2:0] I_SAT_MAG = {2'b0, 1'b1, 46'b0};

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_DT, OP_MUL_ED, OP_ACC, OP_MUL_P, OP_P, OP_MUL_IHI,
    OP_MUL_ILO, OP_ISUM, OP_DIV_I, OP_DIV_STEP, OP_I, OP_MUL_DIFF, OP_MUL_D,
    OP_DIV_D, OP_D, OP_SUM, OP_OUT, OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_NO_ITEM, COND_CLEAR, COND_DIV_MORE, COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  ret;
  } uword_t;

  typedef struct packed {
    logic clr;
    logic div_last;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  localparam pc_t STEP_IDLE  = 5'd0;
  localparam pc_t STEP_DIV_I = 5'd10;
  localparam pc_t STEP_DIV_D = 5'd15;
  localparam pc_t STEP_OUT   = 5'd18;
  localparam pc_t STEP_CLEAR = 5'd20;

  function automatic uword_t mk_uword(input op_t o, input cond_t c, input pc_t t,
                                      input logic r);
    uword_t w;
    w.op = o;
    w.cond = c;
    w.target = t;
    w.ret = r;
    return w;
  endfunction

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:  w = mk_uword(OP_LOAD,     COND_NO_ITEM,  STEP_IDLE,  1'b0);
      5'd1:       w = mk_uword(OP_DT,       COND_CLEAR,    STEP_CLEAR, 1'b0);
      5'd2:       w = mk_uword(OP_MUL_ED,   COND_NEVER,    STEP_IDLE,  1'b0);
      5'd3:       w = mk_uword(OP_ACC,      COND_NEVER,    STEP_IDLE,  1'b0);
      5'd4:       w = mk_uword(OP_MUL_P,    COND_NEVER,    STEP_IDLE,  1'b0);
      5'd5:       w = mk_uword(OP_P,        COND_NEVER,    STEP_IDLE,  1'b0);
      5'd6:       w = mk_uword(OP_MUL_IHI,  COND_NEVER,    STEP_IDLE,  1'b0);
      5'd7:       w = mk_uword(OP_MUL_ILO,  COND_NEVER,    STEP_IDLE,  1'b0);
      5'd8:       w = mk_uword(OP_ISUM,     COND_NEVER,    STEP_IDLE,  1'b0);
      5'd9:       w = mk_uword(OP_DIV_I,    COND_NEVER,    STEP_IDLE,  1'b0);
      STEP_DIV_I: w = mk_uword(OP_DIV_STEP, COND_DIV_MORE, STEP_DIV_I, 1'b0);
      5'd11:      w = mk_uword(OP_I,        COND_NEVER,    STEP_IDLE,  1'b0);
      5'd12:      w = mk_uword(OP_MUL_DIFF, COND_NEVER,    STEP_IDLE,  1'b0);
      5'd13:      w = mk_uword(OP_MUL_D,    COND_NEVER,    STEP_IDLE,  1'b0);
      5'd14:      w = mk_uword(OP_DIV_D,    COND_NEVER,    STEP_IDLE,  1'b0);
      STEP_DIV_D: w = mk_uword(OP_DIV_STEP, COND_DIV_MORE, STEP_DIV_D, 1'b0);
      5'd16:      w = mk_uword(OP_D,        COND_NEVER,    STEP_IDLE,  1'b0);
      5'd17:      w = mk_uword(OP_SUM,      COND_NEVER,    STEP_IDLE,  1'b0);
      STEP_OUT:   w = mk_uword(OP_OUT,      COND_OUT_BUSY, STEP_OUT,   1'b1);
      STEP_CLEAR: w = mk_uword(OP_CLEAR,    COND_OUT_BUSY, STEP_CLEAR, 1'b1);
      default:    w = mk_uword(OP_NOP,      COND_ALWAYS,   STEP_IDLE,  1'b0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/pyc_div.sv]
// radix-4 restoring divider, unsigned, two quotient bits per cycle while step is asserted
// depends on pyc_pkg
`default_nettype none

module pyc_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pyc_pkg::div_ctrl_t               ctrl,
  input  wire logic [pyc_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [pyc_pkg::DIVISOR_W-1:0]    divisor,
  output logic      [pyc_pkg::DIVIDEND_W-1:0]   quotient,
  output logic                                  last
);
  import pyc_pkg::*;

  logic [DIVIDEND_W-1:0] num;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIV_CNT_W-1:0]  cnt;

  logic [DIVISOR_W:0] dv, r1, r1s, r2, r2s;
  logic ge1, ge2;

  always_comb begin
    dv  = {1'b0, dvs};
    r1  = {rem, num[DIVIDEND_W-1]};
    ge1 = (r1 >= dv);
    r1s = ge1 ? (r1 - dv) : r1;
    r2  = {r1s[DIVISOR_W-1:0], num[DIVIDEND_W-2]};
    ge2 = (r2 >= dv);
    r2s = ge2 ? (r2 - dv) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (ctrl.step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (ctrl.step) begin
      num <= {num[DIVIDEND_W-3:0], ge1, ge2};
      rem <= r2s[DIVISOR_W-1:0];
    end
  end

  assign quotient = num;
  assign last     = (cnt == DIV_CNT_W'(1));

endmodule

`default_nettype wire

[src/pyc_seq.sv]
// microcode sequencer: step counter, rom lookup and conditional jumps
// depends on pyc_pkg
`default_nettype none

module pyc_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire pyc_pkg::status_t status,
  output pyc_pkg::op_t          op
);
  import pyc_pkg::*;

  pc_t    pc;
  pc_t    pc_next;
  uword_t uw;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    uw = ucode_rom(pc);
    case (uw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_ITEM:  take = !item_valid;
      COND_CLEAR:    take = status.clr;
      COND_DIV_MORE: take = !status.div_last;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b0;
    endcase
    if (take) begin
      pc_next = uw.target;
    end else if (uw.ret) begin
      pc_next = STEP_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
    op = uw.op;
  end

endmodule

`default_nettype wire

[src/pyc_dp.sv]
// datapath: config registers, controller state, shared multiplier, divider, output register
// depends on pyc_pkg, pyc_div and the assertion header
`default_nettype none

`include "pid_yaw_controller_deadband_core_assert.svh"

module pyc_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pyc_pkg::op_t                     op,
  input  wire logic                             cfg_valid,
  input  wire logic [pyc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pyc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             s_tvalid,
  input  wire logic [pyc_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire logic [pyc_pkg::S_TUSER_W-1:0]    s_tuser,
  input  wire logic                             m_tready,
  output logic                                  m_tvalid,
  output logic      [pyc_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic      [pyc_pkg::M_TUSER_W-1:0]    m_tuser,
  output pyc_pkg::status_t                      status
);
  import pyc_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_BAD = $signed({1'b1, 47'b0});

  function automatic logic signed [TERM_W-1:0] apply_sign(input logic [TERM_W-2:0] m,
                                                          input logic neg);
    logic signed [TERM_W-1:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  // configuration
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [LIMIT_W-1:0] rate_limit, dead_band;
  logic [MS_W-1:0]    period;

  // item and controller state
  logic [CMD_W-1:0]          cmd;
  logic signed [ANGLE_W-1:0] err;
  logic [MS_W-1:0]           dt;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ERR_W-1:0]   last_err;
  logic                      last_valid;
  logic signed [ERR_W-1:0]   diff;
  logic                      d_valid;

  // working registers
  logic [PROD_W-1:0]        prod;
  logic [WIDE_W-1:0]        wide;
  logic                     i_sat;
  logic signed [TERM_W-1:0] p_term, i_term, d_term, sum;

  logic [ANGLE_W-1:0]   abs_err;
  logic [GAIN_W-1:0]    abs_kp, abs_ki, abs_kd;
  logic [ACC_W-2:0]     abs_acc;
  logic [ERR_W-1:0]     abs_diff;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic signed [ACC_W:0] ed_s, acc_sum, acc_sat;
  logic signed [TERM_W-1:0] db_s, rl_s;
  logic signed [RATE_W-1:0] res;
  logic out_busy, write_out;

  div_ctrl_t             div_ctrl;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quo;
  logic                  div_last;

  always_comb begin
    abs_err  = err[ANGLE_W-1] ? ANGLE_W'(-err) : ANGLE_W'(err);
    abs_kp   = kp[GAIN_W-1] ? GAIN_W'(-kp) : GAIN_W'(kp);
    abs_ki   = ki[GAIN_W-1] ? GAIN_W'(-ki) : GAIN_W'(ki);
    abs_kd   = kd[GAIN_W-1] ? GAIN_W'(-kd) : GAIN_W'(kd);
    abs_acc  = acc[ACC_W-1] ? (ACC_W-1)'(-acc) : acc[ACC_W-2:0];
    abs_diff = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);

    case (op)
      OP_MUL_ED: begin
        mul_a = {16'b0, dt};
        mul_b = {10'b0, abs_err};
      end
      OP_MUL_P: begin
        mul_a = abs_kp;
        mul_b = {10'b0, abs_err};
      end
      OP_MUL_IHI: begin
        mul_a = abs_ki;
        mul_b = {2'b0, abs_acc[46:24]};
      end
      OP_MUL_ILO: begin
        mul_a = abs_ki;
        mul_b = {1'b0, abs_acc[23:0]};
      end
      OP_MUL_DIFF: begin
        mul_a = {16'b0, MS_PER_S};
        mul_b = {9'b0, abs_diff};
      end
      OP_MUL_D: begin
        mul_a = abs_kd;
        mul_b = prod[MUL_B_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {25'b0, mul_a} * {32'b0, mul_b};

    ed_s    = err[ANGLE_W-1] ? -$signed({18'b0, prod[30:0]}) : $signed({18'b0, prod[30:0]});
    acc_sum = $signed({acc[ACC_W-1], acc}) + ed_s;
    if (acc_sum > ACC_HI) begin
      acc_sat = ACC_HI;
    end else if (acc_sum < ACC_LO) begin
      acc_sat = ACC_LO;
    end else begin
      acc_sat = acc_sum;
    end

    db_s = $signed({35'b0, dead_band});
    rl_s = $signed({35'b0, rate_limit});
    if (sum <= db_s && sum >= -db_s) begin
      res = '0;
    end else if (sum > rl_s) begin
      res = $signed({1'b0, rate_limit});
    end else if (sum < -rl_s) begin
      res = -$signed({1'b0, rate_limit});
    end else begin
      res = sum[RATE_W-1:0];
    end

    div_ctrl.load = (op == OP_DIV_I) || (op == OP_DIV_D);
    div_ctrl.step = (op == OP_DIV_STEP);
    div_dividend  = (op == OP_DIV_I) ? wide[71:16] : {15'b0, prod[56:16]};
    div_divisor   = (op == OP_DIV_I) ? MS_PER_S : dt;

    out_busy  = m_tvalid && !m_tready;
    write_out = ((op == OP_OUT) || (op == OP_CLEAR)) && !out_busy;

    status.clr      = (cmd != CMD_SAMPLE) || (abs_err <= dead_band);
    status.div_last = div_last;
    status.out_busy = out_busy;
  end

  pyc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .last     (div_last)
  );

  // config and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      kp         <= KP_RESET;
      ki         <= KI_RESET;
      kd         <= KD_RESET;
      rate_limit <= RATE_LIMIT_RESET;
      dead_band  <= DEAD_BAND_RESET;
      period     <= PERIOD_RESET;
      acc        <= '0;
      last_err   <= '0;
      last_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_KP:         kp <= $signed(cfg_data);
          REG_KI:         ki <= $signed(cfg_data);
          REG_KD:         kd <= $signed(cfg_data);
          REG_RATE_LIMIT: rate_limit <= cfg_data[LIMIT_W-1:0];
          REG_DEAD_BAND:  dead_band <= cfg_data[LIMIT_W-1:0];
          REG_PERIOD:     period <= cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      case (op)
        OP_ACC: begin
          acc        <= acc_sat[ACC_W-1:0];
          last_err   <= {err[ANGLE_W-1], err};
          last_valid <= 1'b1;
        end
        OP_CLEAR: begin
          acc        <= '0;
          last_err   <= '0;
          last_valid <= 1'b0;
        end
        default: ;
      endcase
      if (write_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (s_tvalid) begin
          cmd <= s_tuser;
          err <= $signed(s_tdata[ANGLE_W-1:0]);
          dt  <= s_tdata[ANGLE_W+MS_W-1:ANGLE_W];
        end
      end
      OP_DT: begin
        if (dt == '0) begin
          dt <= (period == '0) ? MS_W'(1) : period;
        end
      end
      OP_ACC: begin
        diff    <= $signed({err[ANGLE_W-1], err}) - last_err;
        d_valid <= last_valid;
      end
      OP_MUL_ED, OP_MUL_P, OP_MUL_D, OP_MUL_DIFF: prod <= mul_p;
      OP_MUL_IHI: prod <= mul_p;
      OP_MUL_ILO: begin
        wide <= {prod[55:0], 24'b0};
        prod <= mul_p;
      end
      OP_ISUM:  wide <= wide + {23'b0, prod};
      OP_DIV_I: i_sat <= (wide >= I_SAT_LIM);
      OP_P: p_term <= apply_sign({8'b0, prod[56:16]}, kp[GAIN_W-1] ^ err[ANGLE_W-1]);
      OP_I: i_term <= apply_sign(i_sat ? I_SAT_MAG : {3'b0, div_quo[45:0]},
                                 ki[GAIN_W-1] ^ acc[ACC_W-1]);
      OP_D: d_term <= d_valid ? apply_sign({8'b0, div_quo[40:0]},
                                           kd[GAIN_W-1] ^ diff[ERR_W-1]) : '0;
      OP_SUM: sum <= p_term + i_term + d_term;
      default: ;
    endcase
    if (write_out) begin
      if (op == OP_CLEAR) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= res;
        m_tuser <= 1'b0;
      end
    end
  end

  `PYC_ASSERT_IMPL(a_flag_means_zero, m_tvalid && m_tuser[0], m_tdata == '0)
  `PYC_ASSERT_IMPL(a_acc_in_range, 1'b1, acc != ACC_BAD)
  `PYC_ASSERT_NEXT(a_clear_state, op == OP_CLEAR, acc == '0 && !last_valid)

endmodule

`default_nettype wire

[src/pid_yaw_controller_deadband_core.sv]
// a control sample runs every step up to the output step, with two passes of the radix-4
// divider (integral scaling by 1000, derivative division by dt); other commands and samples
// in the dead band jump to the clear step; items are taken one at a time
// a finished result waits in the output register while the next item is taken
// reset: synchronous; gains, limits and period return to defaults, integral and history clear
// top level: microcode sequencer plus datapath, depends on pyc_pkg, pyc_seq, pyc_dp
`default_nettype none

`include "pid_yaw_controller_deadband_core_assert.svh"

module pid_yaw_controller_deadband_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [pyc_pkg::S_TDATA_W-1:0]    s_tdata,   // heading_error [14:0], elapsed_ms [30:15]
  input  wire logic [pyc_pkg::S_TUSER_W-1:0]    s_tuser,   // command [1:0]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [pyc_pkg::M_TDATA_W-1:0]    m_tdata,   // angular_rate [15:0]
  output logic      [pyc_pkg::M_TUSER_W-1:0]    m_tuser,   // in_dead_band [0]
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pyc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pyc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pyc_pkg::*;

  op_t     op;
  status_t status;

  pyc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_tvalid),
    .status     (status),
    .op         (op)
  );

  pyc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .status    (status)
  );

  assign s_tready  = (op == OP_LOAD);
  assign cfg_ready = 1'b1;

  `PYC_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

[verif/yaw_rate_checker.sv]
`timescale 1ns / 1ps
// checker for the yaw-rate controller: follows register writes and input transfers,
// predicts each result in fixed point and compares it with the output stream
// depends on pyc_pkg only
module yaw_rate_checker
  import pyc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [S_TUSER_W-1:0]  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  input  logic [M_TUSER_W-1:0]  m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic                     dead;
  } rate_result_t;

  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic [127:0] I_CAP = 128'd1 << 46;

  longint kp, ki, kd, rate_lim, dband, period;
  longint integ, prev_err;
  bit prev_ok;
  rate_result_t rate_expected[$];
  int fails = 0;
  int pending_cnt = 0;

  assign mismatches = fails;
  assign outstanding = pending_cnt;

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic rate_result_t predict_rate(input logic [CMD_W-1:0] cmd,
                                                input logic signed [ANGLE_W-1:0] err,
                                                input logic [MS_W-1:0] ms);
    rate_result_t r;
    longint e, d, diff, p_term, i_term, d_term, sum, res;
    logic [127:0] prod, step_ms;
    e = err;
    r.rate = '0;
    r.dead = 1'b1;
    if (cmd != CMD_SAMPLE || mag64(e) <= dband) begin
      integ = 0;
      prev_err = 0;
      prev_ok = 1'b0;
      return r;
    end
    d = (ms != '0) ? longint'(ms) : period;
    if (d == 0) d = 1;

    integ = integ + e * d;
    if (integ > ACC_MAX) integ = ACC_MAX;
    else if (integ < -ACC_MAX) integ = -ACC_MAX;

    // derivative only once a previous error exists
    d_term = 0;
    if (prev_ok) begin
      diff = e - prev_err;
      step_ms = d;
      prod = mag64(kd);
      prod = prod * mag64(diff) * 1000;
      prod = prod / (step_ms << 16);
      d_term = longint'(prod);
      if ((kd < 0) != (diff < 0)) d_term = -d_term;
    end
    prev_err = e;
    prev_ok = 1'b1;

    prod = mag64(kp);
    prod = (prod * mag64(e)) >> 16;
    p_term = longint'(prod);
    if ((kp < 0) != (e < 0)) p_term = -p_term;

    // integral is in rad * ms, so scale by 1/1000 before the gain shift
    prod = mag64(ki);
    prod = ((prod * mag64(integ)) / 1000) >> 16;
    if (prod > I_CAP) prod = I_CAP;
    i_term = longint'(prod);
    if ((ki < 0) != (integ < 0)) i_term = -i_term;

    sum = p_term + i_term + d_term;
    if (mag64(sum) <= dband) res = 0;
    else if (sum > rate_lim) res = rate_lim;
    else if (sum < -rate_lim) res = -rate_lim;
    else res = sum;
    r.rate = res[RATE_W-1:0];
    r.dead = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    rate_result_t want;
    if (rst) begin
      kp = KP_RESET;
      ki = KI_RESET;
      kd = KD_RESET;
      rate_lim = RATE_LIMIT_RESET;
      dband = DEAD_BAND_RESET;
      period = PERIOD_RESET;
      integ = 0;
      prev_err = 0;
      prev_ok = 1'b0;
      rate_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KP:         kp = $signed(cfg_data);
          REG_KI:         ki = $signed(cfg_data);
          REG_KD:         kd = $signed(cfg_data);
          REG_RATE_LIMIT: rate_lim = cfg_data[LIMIT_W-1:0];
          REG_DEAD_BAND:  dband = cfg_data[LIMIT_W-1:0];
          REG_PERIOD:     period = cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      // results are taken before new inputs, a result never belongs to this edge's input
      if (m_tvalid && m_tready) begin
        if (rate_expected.size() == 0) begin
          report_mismatch("unexpected result rate", $signed(m_tdata), 0);
        end else begin
          want = rate_expected.pop_front();
          if ($signed(m_tdata[RATE_W-1:0]) != want.rate)
            report_mismatch("angular rate", $signed(m_tdata[RATE_W-1:0]), want.rate);
          if (m_tuser[0] != want.dead)
            report_mismatch("deadband flag", m_tuser[0], want.dead);
        end
      end
      if (s_tvalid && s_tready)
        rate_expected.push_back(predict_rate(s_tuser, s_tdata[ANGLE_W-1:0],
                                             s_tdata[ANGLE_W+MS_W-1:ANGLE_W]));
    end
    pending_cnt = rate_expected.size();
  end

endmodule

[verif/tb_pid_yaw_controller_deadband_core.sv]
`timescale 1ns / 1ps
// testbench top for the yaw-rate controller: clock, reset, register writes and
// sample stimulus; yaw_rate_checker sits beside the block and counts mismatches
// depends on pyc_pkg, pid_yaw_controller_deadband_core and yaw_rate_checker
module tb_pid_yaw_controller_deadband_core;
  import pyc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NO_TRANSFORM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE        = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 3'd7;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS   = 50;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_LONG} ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // heading_error [14:0], elapsed_ms [30:15]
  logic [S_TUSER_W-1:0]  s_tuser = '0;   // command [1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // angular_rate [15:0]
  logic [M_TUSER_W-1:0]  m_tuser;        // in_dead_band [0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int burst_left = 0;
  int stall_hold = 0;
  ready_mode_t stall_mode = READY_ALWAYS;

  always #6 clk = ~clk;

  pid_yaw_controller_deadband_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  yaw_rate_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver backpressure, in a mode picked at random from always, half, sparse and long holds
  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode = ready_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      READY_ALWAYS: m_tready = 1'b1;
      READY_HALF:   m_tready = $urandom_range(0, 1);
      READY_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_hold == 0) begin
          m_tready = ~m_tready;
          stall_hold = $urandom_range(1, 30);
        end else begin
          stall_hold--;
        end
      end
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(input logic [CMD_W-1:0] cmd, input logic [ANGLE_W-1:0] err,
                             input logic [MS_W-1:0] ms);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(13, 100);
        default: gap = $urandom_range(1, 12);
      endcase
      burst_left = $urandom_range(1, 24);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {1'b0, ms, err};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] g;
    case ($urandom_range(0, 5))
      0: g = 32'h8000_0000;
      1: g = 32'h7FFF_FFFF;
      2: g = '0;
      3: g = $urandom;
      default: begin
        g = $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(0, 1)) g = -g;
      end
    endcase
    return g;
  endfunction

  // 15-bit register value, upper bits of the write carry junk
  function automatic logic [CFG_DATA_W-1:0] pick_span(input int typical_hi);
    logic [CFG_DATA_W-1:0] v;
    v = $urandom & ~32'h7FFF;
    case ($urandom_range(0, 5))
      0:       v[LIMIT_W-1:0] = '0;
      1:       v[LIMIT_W-1:0] = '1;
      2:       v[LIMIT_W-1:0] = $urandom;
      default: v[LIMIT_W-1:0] = $urandom_range(0, typical_hi);
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int err;
    int ms;
    logic [CFG_DATA_W-1:0] per;
    logic [CMD_W-1:0] cmd;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // state-clearing commands, deadband edges, field extremes, default period
    send_sample(CMD_NO_TRANSFORM, 1000, 10);
    send_sample(CMD_RESTART, -1000, 0);
    send_sample(CMD_SPARE, 16383, 65535);
    send_sample(CMD_SAMPLE, 0, 100);
    send_sample(CMD_SAMPLE, 4, 100);
    send_sample(CMD_SAMPLE, -4, 100);
    send_sample(CMD_SAMPLE, 5, 100);
    send_sample(CMD_SAMPLE, -5, 100);
    send_sample(CMD_SAMPLE, 12868, 0);
    send_sample(CMD_SAMPLE, -12868, 65535);
    send_sample(CMD_SAMPLE, 16383, 1);
    send_sample(CMD_SAMPLE, -16384, 1);
    send_sample(CMD_NO_TRANSFORM, 3000, 5);
    send_sample(CMD_SAMPLE, 3000, 5);

    // extreme gains, zero deadband, zero default period
    wait_drained();
    write_reg(REG_KP, 32'h8000_0000);
    write_reg(REG_KI, 32'h7FFF_FFFF);
    write_reg(REG_KD, 32'h7FFF_FFFF);
    write_reg(REG_RATE_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_DEAD_BAND, 32'h0);
    write_reg(REG_PERIOD, 32'h0);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_sample(CMD_SAMPLE, 1, 0);
    send_sample(CMD_SAMPLE, -1, 0);
    send_sample(CMD_SAMPLE, 0, 0);
    send_sample(CMD_SAMPLE, 16383, 1);
    send_sample(CMD_SAMPLE, -16384, 65535);
    send_sample(CMD_RESTART, 0, 0);
    send_sample(CMD_SAMPLE, 200, 7);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      write_reg(REG_KP, pick_gain());
      write_reg(REG_KI, pick_gain());
      write_reg(REG_KD, pick_gain());
      write_reg(REG_RATE_LIMIT, pick_span(8192));
      write_reg(REG_DEAD_BAND, pick_span(48));
      case ($urandom_range(0, 5))
        0:       per = 32'h0;
        1:       per = 32'h1;
        2:       per = 32'hFFFF;
        3:       per = $urandom;
        default: per = $urandom_range(20, 200);
      endcase
      write_reg(REG_PERIOD, per);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) wait_drained();
        cmd = CMD_SAMPLE;
        if ($urandom_range(0, 9) == 0) cmd = $urandom_range(1, 3);
        case ($urandom_range(0, 4))
          0, 1: begin
            err = $urandom_range(0, 64);
            if ($urandom_range(0, 1)) err = -err;
          end
          2, 3:    err = int'($urandom_range(0, 25736)) - 12868;
          default: err = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0, 1:    ms = 0;
          2:       ms = 1;
          3, 4:    ms = $urandom;
          default: ms = $urandom_range(1, 200);
        endcase
        send_sample(cmd, err, ms);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/pyc_pkg.sv
src/pyc_div.sv
src/pyc_seq.sv
src/pyc_dp.sv
src/pid_yaw_controller_deadband_core.sv
verif/yaw_rate_checker.sv
verif/tb_pid_yaw_controller_deadband_core.sv
